/* rtl/vtba_pkg.sv */
// Shared types, constants and arctangent table for the bearing CORDIC pipeline.
package vtba_pkg;

  // Coordinate and angle formats
  localparam int COORD_BITS   = 16;  // significant low bits of each 16-bit coordinate field
  localparam int GUARD_BITS   = 24;  // fraction bits added under the coordinates
  localparam int ITERATIONS   = 16;  // CORDIC micro-rotations
  localparam int ATAN_ENTRIES = 24;
  localparam int ANGLE_BITS   = 32;  // accumulator, 2^32 units per turn
  localparam int BEARING_BITS = 16;

  // Working width: coordinate, guard bits, CORDIC gain and sign headroom
  localparam int W = COORD_BITS + GUARD_BITS + 3;

  // One register stage per micro-rotation
  localparam int STAGES = (ITERATIONS < ATAN_ENTRIES) ? ITERATIONS : ATAN_ENTRIES;

  // Start to strobe: setup stage, rotation stages, output stage
  localparam int LATENCY = STAGES + 2;

  localparam logic [ANGLE_BITS-1:0] HALF_TURN  = 32'h8000_0000;
  localparam logic [ANGLE_BITS-1:0] ROUND_BIAS = 32'h0000_8000;

  localparam logic [BEARING_BITS-1:0] BEARING_UP   = 16'h0000;
  localparam logic [BEARING_BITS-1:0] BEARING_DOWN = 16'h8000;

  // atan(2^-i), rounded, in 2^32-per-turn units
  localparam logic [ANGLE_BITS-1:0] ATAN_UNITS [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Pipeline word carried from stage to stage
  typedef struct packed {
    logic                   vld;
    logic                   dx_zero;  // horizontal component is zero
    logic                   dy_pos;   // vertical component points down
    logic signed [W-1:0]    u;
    logic signed [W-1:0]    v;
    logic [ANGLE_BITS-1:0]  z;
  } stage_t;

endpackage

/* rtl/vector_to_bearing_angle.sv */
// Top level of the screen-vector bearing unit (pipelined CORDIC atan2).
//
// Usage:
//   Drive in_vec_x / in_vec_y (signed, y grows downward) and pulse start.
//   A transaction is accepted on every rising edge with start high and busy
//   low; busy never rises, so a new vector may enter every cycle.
//   The bearing (clockwise from up, 65536 units per turn) appears on
//   out_bearing for exactly one cycle with out_strobe high, once the
//   transaction has passed one setup stage, one stage per CORDIC
//   micro-rotation (16) and one rounding stage.
//   Throughput is one transaction per clock; each rotation stage holds its
//   own adders, so nothing is shared between transactions in flight.
//   The receiver cannot stall; results must be captured on the strobe.
//   Synchronous active-low reset clears every stage's valid bit, so no
//   strobe follows reset until new transactions arrive. Data in flight at
//   reset is dropped.
module vector_to_bearing_angle import vtba_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [15:0]              in_vec_x,
  input  logic [15:0]              in_vec_y,
  output logic                     out_strobe,
  output logic [BEARING_BITS-1:0]  out_bearing
);

  stage_t prep_s;
  stage_t cordic_s;

  // Fully pipelined: always ready
  assign busy = 1'b0;

  vtba_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_vec_x (in_vec_x),
    .in_vec_y (in_vec_y),
    .prep_r   (prep_s)
  );

  vtba_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .s_in  (prep_s),
    .s_out (cordic_s)
  );

  vtba_round u_round (
    .clk         (clk),
    .rst_n       (rst_n),
    .s_in        (cordic_s),
    .out_strobe  (out_strobe),
    .out_bearing (out_bearing)
  );

  // Every accepted transaction produces a strobe once through the pipeline
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("accepted transaction produced no result");

  // No result without an accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LATENCY !out_strobe)
    else $error("result strobe without a transaction");

  // Zero horizontal component pointing down gives half a turn
  a_zero_dx_down: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_vec_x == '0) && !in_vec_y[15] && (in_vec_y != '0))
    |-> ##LATENCY (out_bearing == BEARING_DOWN))
    else $error("zero-dx downward vector has wrong bearing");

  // Zero horizontal component pointing up or null gives zero
  a_zero_dx_up: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_vec_x == '0) && (in_vec_y[15] || (in_vec_y == '0)))
    |-> ##LATENCY (out_bearing == BEARING_UP))
    else $error("zero-dx upward vector has wrong bearing");

endmodule

/* rtl/vtba_prep.sv */
// Setup stage: sign-extend, scale and fold the vector into the right half-plane.
module vtba_prep import vtba_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [15:0]  in_vec_x,
  input  logic [15:0]  in_vec_y,
  output stage_t       prep_r
);

  logic signed [W-1:0] dx_s;
  logic signed [W-1:0] dy_s;
  stage_t              prep_nxt;

  // Sign-extend the low coordinate bits and shift in the guard bits
  assign dx_s = {{(W-COORD_BITS){in_vec_x[COORD_BITS-1]}}, in_vec_x[COORD_BITS-1:0]}
                <<< GUARD_BITS;
  assign dy_s = {{(W-COORD_BITS){in_vec_y[COORD_BITS-1]}}, in_vec_y[COORD_BITS-1:0]}
                <<< GUARD_BITS;

  // (u, v) = (-dy, dx); a downward vector is turned half a turn first
  always_comb begin
    prep_nxt.vld     = start;
    prep_nxt.dx_zero = (dx_s == '0);
    prep_nxt.dy_pos  = !dy_s[W-1] && (dy_s != '0);
    if (prep_nxt.dy_pos) begin
      prep_nxt.u = dy_s;
      prep_nxt.v = -dx_s;
      prep_nxt.z = HALF_TURN;
    end else begin
      prep_nxt.u = -dy_s;
      prep_nxt.v = dx_s;
      prep_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r <= '0;
    end else begin
      prep_r <= prep_nxt;
    end
  end

endmodule

/* rtl/vtba_cordic.sv */
// Unrolled vectoring CORDIC: one registered micro-rotation per stage.
module vtba_cordic import vtba_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  stage_t  s_in,
  output stage_t  s_out
);

  stage_t pipe_r [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    stage_t              src;
    stage_t              stage_nxt;
    logic signed [W-1:0] us;
    logic signed [W-1:0] vs;

    if (k == 0) begin : g_first
      assign src = s_in;
    end else begin : g_next
      assign src = pipe_r[k-1];
    end

    // Arithmetic shifts round toward minus infinity
    assign us = src.u >>> k;
    assign vs = src.v >>> k;

    // Rotate toward the u axis, steering by the sign of v
    always_comb begin
      stage_nxt = src;
      if (!src.v[W-1]) begin
        stage_nxt.u = src.u + vs;
        stage_nxt.v = src.v - us;
        stage_nxt.z = src.z + ATAN_UNITS[k];
      end else begin
        stage_nxt.u = src.u - vs;
        stage_nxt.v = src.v + us;
        stage_nxt.z = src.z - ATAN_UNITS[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pipe_r[k] <= '0;
      end else begin
        pipe_r[k] <= stage_nxt;
      end
    end
  end

  assign s_out = pipe_r[STAGES-1];

endmodule

/* rtl/vtba_round.sv */
// Output stage: round the accumulator to 16 bits and apply the zero-dx override.
module vtba_round import vtba_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  stage_t                   s_in,
  output logic                     out_strobe,
  output logic [BEARING_BITS-1:0]  out_bearing
);

  logic                     strobe_r;
  logic [BEARING_BITS-1:0]  bearing_r;
  logic [BEARING_BITS-1:0]  bearing_nxt;
  logic [ANGLE_BITS-1:0]    z_rnd;

  // Round to nearest; a full turn wraps to zero in the truncation
  assign z_rnd = s_in.z + ROUND_BIAS;

  always_comb begin
    if (s_in.dx_zero) begin
      bearing_nxt = s_in.dy_pos ? BEARING_DOWN : BEARING_UP;
    end else begin
      bearing_nxt = z_rnd[ANGLE_BITS-1 -: BEARING_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= s_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    bearing_r <= bearing_nxt;
  end

  assign out_strobe  = strobe_r;
  assign out_bearing = bearing_r;

endmodule
